FILE: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Next-cycle implication, muted while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: sv/scc_pkg.sv
package scc_pkg;

	localparam int DEF_COUNT_WIDTH = 16;

	localparam int SAMPLE_W    = 16;
	localparam int SPEED_W     = 16;
	localparam int DUR_W       = 16;
	localparam int PRESS_CFG_W = 15;
	localparam int THRESH_W    = 14;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	// speed band edges, strictly-above compares
	localparam logic [SPEED_W-1:0] SPEED_FLOOR = 16'h1400;
	localparam logic [SPEED_W-1:0] EDGE_B9     = 16'h7800;
	localparam logic [SPEED_W-1:0] EDGE_B8     = 16'h6E00;
	localparam logic [SPEED_W-1:0] EDGE_B7     = 16'h6400;
	localparam logic [SPEED_W-1:0] EDGE_B6     = 16'h5A00;
	localparam logic [SPEED_W-1:0] EDGE_B5     = 16'h5000;
	localparam logic [SPEED_W-1:0] EDGE_B4     = 16'h4600;
	localparam logic [SPEED_W-1:0] EDGE_B3     = 16'h3C00;
	localparam logic [SPEED_W-1:0] EDGE_B2     = 16'h3200;
	localparam logic [SPEED_W-1:0] EDGE_B1     = 16'h2800;

	localparam logic [1:0] CUT_BITS = 2'b11;

	// register reset values
	localparam logic [63:0]            RST_HIGH_BANDS = 64'd105554593755693337;
	localparam logic [63:0]            RST_MID_BANDS  = 64'd70088205516079260;
	localparam logic [31:0]            RST_LOW_BANDS  = 32'd8126557;
	localparam logic [PRESS_CFG_W-1:0] RST_MIN_PRESS  = 15'd5;
	localparam logic [PRESS_CFG_W-1:0] RST_REARM      = 15'd500;
	localparam logic                   RST_FUEL_EN    = 1'b1;
	localparam logic                   RST_IGN_EN     = 1'b1;
	localparam logic [THRESH_W-1:0]    RST_THRESHOLD  = 14'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIGH_BANDS = 3'd0,
		REG_MID_BANDS  = 3'd1,
		REG_LOW_BANDS  = 3'd2,
		REG_MIN_PRESS  = 3'd3,
		REG_REARM      = 3'd4,
		REG_FUEL_EN    = 3'd5,
		REG_IGN_EN     = 3'd6,
		REG_THRESHOLD  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [63:0]            high_bands;
		logic [63:0]            mid_bands;
		logic [31:0]            low_bands;
		logic [PRESS_CFG_W-1:0] min_press;
		logic [PRESS_CFG_W-1:0] rearm;
		logic                   fuel_en;
		logic                   ign_en;
		logic [THRESH_W-1:0]    threshold;
	} cfg_t;

	typedef struct packed {
		logic       cut_active;
		logic [1:0] fuel_cut_mask;
		logic [1:0] ign_cut_mask;
	} res_t;

endpackage

FILE: sv/scc_if.sv
interface scc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] sensor_sample;
	logic [15:0] engine_speed;

	modport source (output valid, output sensor_sample, output engine_speed, input ready);
	modport sink   (input valid, input sensor_sample, input engine_speed, output ready);
endinterface

interface scc_out_if;
	logic       valid;
	logic       ready;
	logic       cut_active;
	logic [1:0] fuel_cut_mask;
	logic [1:0] ign_cut_mask;

	modport source (output valid, output cut_active, output fuel_cut_mask,
		output ign_cut_mask, input ready);
	modport sink   (input valid, input cut_active, input fuel_cut_mask,
		input ign_cut_mask, output ready);
endinterface

interface scc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/scc_cfg_regs.sv
module scc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [scc_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [scc_pkg::CFG_DATA_W-1:0]      wr_data,
	output scc_pkg::cfg_t                       cfg
);

	scc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_bands <= scc_pkg::RST_HIGH_BANDS;
			cfg_q.mid_bands  <= scc_pkg::RST_MID_BANDS;
			cfg_q.low_bands  <= scc_pkg::RST_LOW_BANDS;
			cfg_q.min_press  <= scc_pkg::RST_MIN_PRESS;
			cfg_q.rearm      <= scc_pkg::RST_REARM;
			cfg_q.fuel_en    <= scc_pkg::RST_FUEL_EN;
			cfg_q.ign_en     <= scc_pkg::RST_IGN_EN;
			cfg_q.threshold  <= scc_pkg::RST_THRESHOLD;
		end else if (wr_en) begin
			case (scc_pkg::cfg_idx_t'(wr_index))
				scc_pkg::REG_HIGH_BANDS: cfg_q.high_bands <= wr_data;
				scc_pkg::REG_MID_BANDS:  cfg_q.mid_bands  <= wr_data;
				scc_pkg::REG_LOW_BANDS:  cfg_q.low_bands  <= wr_data[31:0];
				scc_pkg::REG_MIN_PRESS:  cfg_q.min_press  <= wr_data[scc_pkg::PRESS_CFG_W-1:0];
				scc_pkg::REG_REARM:      cfg_q.rearm      <= wr_data[scc_pkg::PRESS_CFG_W-1:0];
				scc_pkg::REG_FUEL_EN:    cfg_q.fuel_en    <= wr_data[0];
				scc_pkg::REG_IGN_EN:     cfg_q.ign_en     <= wr_data[0];
				scc_pkg::REG_THRESHOLD:  cfg_q.threshold  <= wr_data[scc_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/scc_band_sel.sv
// Priority select of the cut duration from ten speed bands.
module scc_band_sel (
	input  logic [scc_pkg::SPEED_W-1:0] speed,
	input  scc_pkg::cfg_t               cfg,
	output logic [scc_pkg::DUR_W-1:0]   duration
);

	always_comb begin
		if (speed > scc_pkg::EDGE_B9) begin
			duration = cfg.high_bands[63:48];
		end else if (speed > scc_pkg::EDGE_B8) begin
			duration = cfg.high_bands[47:32];
		end else if (speed > scc_pkg::EDGE_B7) begin
			duration = cfg.high_bands[31:16];
		end else if (speed > scc_pkg::EDGE_B6) begin
			duration = cfg.high_bands[15:0];
		end else if (speed > scc_pkg::EDGE_B5) begin
			duration = cfg.mid_bands[63:48];
		end else if (speed > scc_pkg::EDGE_B4) begin
			duration = cfg.mid_bands[47:32];
		end else if (speed > scc_pkg::EDGE_B3) begin
			duration = cfg.mid_bands[31:16];
		end else if (speed > scc_pkg::EDGE_B2) begin
			duration = cfg.mid_bands[15:0];
		end else if (speed > scc_pkg::EDGE_B1) begin
			duration = cfg.low_bands[31:16];
		end else begin
			duration = cfg.low_bands[15:0];
		end
	end

endmodule

FILE: sv/scc_core.sv
// Per-tick state update: switch latch, press count, cut / rearm phase counter.
module scc_core #(
	parameter int COUNT_WIDTH = scc_pkg::DEF_COUNT_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [scc_pkg::SAMPLE_W-1:0] sample,
	input  logic [scc_pkg::SPEED_W-1:0]  speed,
	input  scc_pkg::cfg_t                cfg,
	output scc_pkg::res_t                res
);

	// common compare width for counters against 15/16-bit settings
	localparam int CMP_W = (COUNT_WIDTH > scc_pkg::DUR_W) ? COUNT_WIDTH : scc_pkg::DUR_W;

	logic                       started_q, started_d;
	logic                       latched_q, latched_d;
	logic                       cutting_q, cutting_d;
	logic [COUNT_WIDTH-1:0]     phase_q, phase_d;
	logic [COUNT_WIDTH-1:0]     press_q, press_d;
	logic [scc_pkg::DUR_W-1:0]  dur_q, dur_d;
	logic [scc_pkg::DUR_W-1:0]  band_dur;
	logic [CMP_W-1:0]           rearm_w;
	logic [COUNT_WIDTH-1:0]     rearm_load;
	logic                       pressed;

	scc_band_sel u_band_sel (
		.speed    (speed),
		.cfg      (cfg),
		.duration (band_dur)
	);

	assign rearm_w    = CMP_W'(cfg.rearm);
	assign rearm_load = rearm_w[COUNT_WIDTH-1:0];
	assign pressed    = (sample[scc_pkg::SAMPLE_W-1:2] <= cfg.threshold);

	always_comb begin
		started_d = started_q;
		latched_d = latched_q;
		cutting_d = cutting_q;
		phase_d   = phase_q;
		press_d   = press_q;
		dur_d     = dur_q;

		// first tick after reset
		if (!started_q) begin
			cutting_d = 1'b0;
			latched_d = 1'b0;
			press_d   = '0;
			phase_d   = rearm_load;
			started_d = 1'b1;
		end

		if (pressed) begin
			if (speed > scc_pkg::SPEED_FLOOR) begin
				latched_d = 1'b1;
				dur_d     = band_dur;
			end
		end else begin
			latched_d = 1'b0;
		end

		if (cutting_d) begin
			phase_d = phase_d + COUNT_WIDTH'(1);
			if (CMP_W'(phase_d) >= CMP_W'(dur_d)) begin
				cutting_d = 1'b0;
				phase_d   = rearm_load;
			end
		end else if (phase_d != '0) begin
			// rearm countdown only on released ticks
			if (!latched_d) begin
				phase_d = phase_d - COUNT_WIDTH'(1);
			end
		end else if (latched_d) begin
			press_d = press_d + COUNT_WIDTH'(1);
			if (CMP_W'(press_d) >= CMP_W'(cfg.min_press)) begin
				cutting_d = 1'b1;
				phase_d   = '0;
			end
		end else begin
			press_d = '0;
		end
	end

	always_comb begin
		res.cut_active    = cutting_d;
		res.fuel_cut_mask = (cutting_d && cfg.fuel_en) ? scc_pkg::CUT_BITS : 2'b00;
		res.ign_cut_mask  = (cutting_d && cfg.ign_en)  ? scc_pkg::CUT_BITS : 2'b00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			latched_q <= 1'b0;
			cutting_q <= 1'b0;
			phase_q   <= '0;
			press_q   <= '0;
			dur_q     <= '0;
		end else if (step) begin
			started_q <= started_d;
			latched_q <= latched_d;
			cutting_q <= cutting_d;
			phase_q   <= phase_d;
			press_q   <= press_d;
			dur_q     <= dur_d;
		end
	end

endmodule

FILE: sv/shift_cut_controller_unit.sv
// Shift cut controller. Each item on sample_ch is one fuel-loop tick (sensor sample
// and engine speed); for every item exactly one result item leaves on result_ch
// with the cut flag and the fuel / ignition cut masks, in order. An item is
// registered on entry, the whole tick update (press test, band pick, press and
// phase counters) runs combinationally against the controller state, and the result
// lands in an output register. Throughput is one item per clock unless result_ch
// stalls. The output register decouples the two sides, so a new item is taken while
// a finished result still waits, and sample_ch.ready only drops when both stages
// hold items and result_ch is stalled. Configuration writes on cfg_ch are always
// accepted and take effect at once; write them only while no item is in flight.
// COUNT_WIDTH sets the width of the press and phase counters, which wrap at that
// width.
module shift_cut_controller_unit #(
	parameter int COUNT_WIDTH = scc_pkg::DEF_COUNT_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	scc_in_if.sink       sample_ch,
	scc_out_if.source    result_ch,
	scc_cfg_if.sink      cfg_ch
);

	scc_pkg::cfg_t cfg;
	scc_pkg::res_t res_next;

	// input stage
	logic                         valid_s1;
	logic [scc_pkg::SAMPLE_W-1:0] sample_s1;
	logic [scc_pkg::SPEED_W-1:0]  speed_s1;

	// result stage
	logic          valid_s2;
	scc_pkg::res_t res_s2;

	logic advance;

	// config regs: no backpressure
	assign cfg_ch.ready = 1'b1;

	scc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_ch.valid),
		.wr_index (cfg_ch.index),
		.wr_data  (cfg_ch.data),
		.cfg      (cfg)
	);

	// item in s1 moves on when the result slot is free or being drained
	assign advance         = valid_s1 && (!valid_s2 || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready) begin
			sample_s1 <= sample_ch.sensor_sample;
			speed_s1  <= sample_ch.engine_speed;
		end
	end

	// controller state steps once per item, as it leaves s1
	scc_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.sample (sample_s1),
		.speed  (speed_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result_ch.valid         = valid_s2;
	assign result_ch.cut_active    = res_s2.cut_active;
	assign result_ch.fuel_cut_mask = res_s2.fuel_cut_mask;
	assign result_ch.ign_cut_mask  = res_s2.ign_cut_mask;

endmodule

FILE: sv/scc_checker.sv
`include "assert_macros.svh"

module scc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       cut_active,
	input logic [1:0] fuel_mask,
	input logic [1:0] ign_mask
);

	// masks only ever show while a cut is on
	`ASSERT_IMPLIES(a_mask_needs_cut, clk, arst_n, out_valid && (fuel_mask != 2'b00 || ign_mask != 2'b00), cut_active)

	// masks are all-or-nothing
	`ASSERT_IMPLIES(a_mask_codes, clk, arst_n, out_valid, (fuel_mask == 2'b00 || fuel_mask == 2'b11) && (ign_mask == 2'b00 || ign_mask == 2'b11))

	// a draining output side never stalls the input side
	`ASSERT_IMPLIES(a_ready_passes, clk, arst_n, out_ready, in_ready)

	// stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(cut_active) && $stable(fuel_mask) && $stable(ign_mask))

endmodule

bind shift_cut_controller_unit scc_checker u_scc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (sample_ch.ready),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.cut_active (result_ch.cut_active),
	.fuel_mask  (result_ch.fuel_cut_mask),
	.ign_mask   (result_ch.ign_cut_mask)
);
